// File: hdl/key_value_stream_parser_macros.svh
// Assertion macros for the key/value stream parser.
// Used by the top level; the enclosing module must have i_clk and i_rst_n.
`ifndef KEY_VALUE_STREAM_PARSER_MACROS_SVH
`define KEY_VALUE_STREAM_PARSER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define KVSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define KVSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kvsp_pkg.sv
// Shared types and constants for the key/value stream parser.
// No dependencies; imported by every module of the block.
package kvsp_pkg;

    localparam int DEF_OFFSET_BITS      = 32;
    localparam int DEF_MAX_PREFIX_BYTES = 4;
    localparam int GROUP_W              = 7;
    localparam int CONT_BIT             = 7;
    localparam int FAIL_OFFSET_W        = 32;
    localparam int PAYLOAD_SIZE_W       = 28;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_PREFIX  = 3'd0,
        ROLE_HEADER  = 3'd1,
        ROLE_KEY     = 3'd2,
        ROLE_VALUE   = 3'd3,
        ROLE_IGNORED = 3'd4
    } t_role;

    typedef enum logic [2:0] {
        ST_RUNNING  = 3'd0,
        ST_DONE     = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_SHORT    = 3'd3,
        ST_KEY_LEN  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]                out_byte;
        t_role                     byte_role;
        logic                      str_key;
        logic                      record_end;
        t_status                   status;
        logic [FAIL_OFFSET_W-1:0]  fail_offset;
        logic [PAYLOAD_SIZE_W-1:0] payload_size;
    } t_out_item;

endpackage

// File: hdl/kvsp_in_reg.sv
// Input register of the key/value stream parser.
// Holds one accepted transfer until the parser stage consumes it; uses kvsp_pkg.
module kvsp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kvsp_pkg::t_in_item i_data,
    input  logic              i_advance,
    output logic              o_valid,
    output kvsp_pkg::t_in_item o_data
);
    import kvsp_pkg::*;

    logic     r_valid;
    t_in_item r_data;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hdl/kvsp_parser.sv
// Record state and per-byte decode logic of the key/value stream parser.
// Produces the result for the held byte and updates state on advance; uses kvsp_pkg.
module kvsp_parser #(
    parameter int OFFSET_BITS      = kvsp_pkg::DEF_OFFSET_BITS,
    parameter int MAX_PREFIX_BYTES = kvsp_pkg::DEF_MAX_PREFIX_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  kvsp_pkg::t_in_item  i_item,
    output kvsp_pkg::t_out_item o_result
);
    import kvsp_pkg::*;

    localparam int ACC_BITS = GROUP_W * MAX_PREFIX_BYTES;
    localparam int CNT_BITS = $clog2(MAX_PREFIX_BYTES + 2);
    localparam int CMP_W    = (ACC_BITS > GROUP_W) ? ACC_BITS : GROUP_W;

    t_phase                 r_phase, n_phase;
    logic [ACC_BITS-1:0]    r_length_accum, n_length_accum;
    logic [CNT_BITS-1:0]    r_prefix_count, n_prefix_count;
    logic [ACC_BITS-1:0]    r_payload_left, n_payload_left;
    logic [GROUP_W-1:0]     r_key_left, n_key_left;
    logic                   r_key_kind, n_key_kind;
    logic                   r_key_too_long, n_key_too_long;
    logic                   r_halted, n_halted;
    logic [OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    logic [OFFSET_BITS-1:0] r_record_start, n_record_start;

    t_role                  role;
    t_status                status;
    logic                   str_key;
    logic                   record_end;
    logic                   ends;
    logic                   failed;
    logic [ACC_BITS-1:0]    size_src;
    logic [ACC_BITS+PAYLOAD_SIZE_W-1:0]   size_ext;
    logic [OFFSET_BITS+FAIL_OFFSET_W-1:0] fail_ext;

    always_comb begin
        n_phase        = r_phase;
        n_length_accum = r_length_accum;
        n_prefix_count = r_prefix_count;
        n_payload_left = r_payload_left;
        n_key_left     = r_key_left;
        n_key_kind     = r_key_kind;
        n_key_too_long = r_key_too_long;
        n_halted       = r_halted;
        n_record_start = r_record_start;
        n_byte_offset  = r_byte_offset + OFFSET_BITS'(1);
        role           = ROLE_IGNORED;
        status         = ST_RUNNING;
        str_key        = 1'b0;
        record_end     = 1'b0;
        ends           = 1'b0;
        size_src       = '0;

        if (!r_halted) begin
            case (r_phase)
                PH_HEADER: begin
                    role           = ROLE_HEADER;
                    str_key        = i_item.in_byte[CONT_BIT];
                    n_key_kind     = i_item.in_byte[CONT_BIT];
                    n_key_left     = i_item.in_byte[GROUP_W-1:0];
                    n_payload_left = r_payload_left - ACC_BITS'(1);
                    n_key_too_long = CMP_W'(i_item.in_byte[GROUP_W-1:0]) > CMP_W'(n_payload_left);
                    size_src       = r_length_accum;
                    if (n_payload_left == '0) begin
                        ends = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                        if (i_item.is_last) begin
                            status = ST_SHORT;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (r_key_left != '0) begin
                        role       = ROLE_KEY;
                        n_key_left = r_key_left - GROUP_W'(1);
                    end else begin
                        role = ROLE_VALUE;
                    end
                    n_payload_left = r_payload_left - ACC_BITS'(1);
                    str_key        = r_key_kind;
                    size_src       = r_length_accum;
                    if (n_payload_left == '0) begin
                        ends = 1'b1;
                    end else if (i_item.is_last) begin
                        status = ST_SHORT;
                    end
                end
                default: begin
                    role = ROLE_PREFIX;
                    if (r_prefix_count == '0) begin
                        n_record_start = r_byte_offset;
                    end
                    n_prefix_count = r_prefix_count + CNT_BITS'(1);
                    if (n_prefix_count > CNT_BITS'(MAX_PREFIX_BYTES)) begin
                        status = ST_BAD_LEN;
                    end else begin
                        n_length_accum = (r_length_accum << GROUP_W)
                                       | ACC_BITS'(i_item.in_byte[GROUP_W-1:0]);
                        if (!i_item.in_byte[CONT_BIT]) begin
                            if (n_length_accum == '0) begin
                                status = ST_BAD_LEN;
                            end else begin
                                n_payload_left = n_length_accum;
                                n_phase        = PH_HEADER;
                                if (i_item.is_last) begin
                                    status = ST_SHORT;
                                end
                            end
                        end else if (i_item.is_last) begin
                            status = (n_length_accum == '0) ? ST_BAD_LEN : ST_SHORT;
                        end
                    end
                    size_src = n_length_accum;
                end
            endcase
        end

        if (ends) begin
            if (n_key_too_long) begin
                status = ST_KEY_LEN;
            end else begin
                record_end = 1'b1;
                if (i_item.is_last) begin
                    status = ST_DONE;
                end
            end
            n_phase        = PH_PREFIX;
            n_length_accum = '0;
            n_prefix_count = '0;
            n_payload_left = '0;
            n_key_left     = '0;
            n_key_kind     = 1'b0;
            n_key_too_long = 1'b0;
        end

        failed = (status == ST_BAD_LEN) || (status == ST_SHORT) || (status == ST_KEY_LEN);
        if (failed && !i_item.is_last) begin
            n_halted = 1'b1;
        end

        size_ext = {{PAYLOAD_SIZE_W{1'b0}}, size_src};
        fail_ext = {{FAIL_OFFSET_W{1'b0}}, n_record_start};

        if (i_item.is_last) begin
            n_phase        = PH_PREFIX;
            n_length_accum = '0;
            n_prefix_count = '0;
            n_payload_left = '0;
            n_key_left     = '0;
            n_key_kind     = 1'b0;
            n_key_too_long = 1'b0;
            n_halted       = 1'b0;
            n_byte_offset  = '0;
            n_record_start = '0;
        end
    end

    always_comb begin
        o_result.out_byte     = i_item.in_byte;
        o_result.byte_role    = role;
        o_result.str_key      = str_key;
        o_result.record_end   = record_end;
        o_result.status       = status;
        o_result.fail_offset  = failed ? fail_ext[FAIL_OFFSET_W-1:0] : '0;
        o_result.payload_size = size_ext[PAYLOAD_SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_PREFIX;
            r_length_accum <= '0;
            r_prefix_count <= '0;
            r_payload_left <= '0;
            r_key_left     <= '0;
            r_key_kind     <= 1'b0;
            r_key_too_long <= 1'b0;
            r_halted       <= 1'b0;
            r_byte_offset  <= '0;
            r_record_start <= '0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_length_accum <= n_length_accum;
            r_prefix_count <= n_prefix_count;
            r_payload_left <= n_payload_left;
            r_key_left     <= n_key_left;
            r_key_kind     <= n_key_kind;
            r_key_too_long <= n_key_too_long;
            r_halted       <= n_halted;
            r_byte_offset  <= n_byte_offset;
            r_record_start <= n_record_start;
        end
    end

endmodule

// File: hdl/key_value_stream_parser.sv
// Key/value stream parser: one byte of a length-prefixed record buffer in, one tagged byte out.
// The input stream is a valid/ready channel of bytes, each with a flag marking the last byte
// of its buffer. The output channel carries the same byte back with its role in the record
// (length prefix, key header, key, value, or ignored after an error), the string-key flag,
// a record-end marker, a status code, the start offset of a failed record and the decoded
// payload length. Every input transfer produces exactly one output transfer, in order.
// An accepted byte is held in the input register and decoded there; when it advances,
// its result is captured in the output register, which offers it to the receiver.
// Throughput is one byte per cycle while the receiver keeps ready high: the decode is
// a single pass of counter and compare logic on the record state, which is updated as
// each result is captured.
// When the receiver stalls, the output register holds its result and the input register
// keeps, or if empty takes, one byte; the input side then stalls until the output drains.
// The first error in a buffer is reported once; later bytes up to the last are ignored.
// A byte marked last always ends the buffer and the next byte starts at offset zero.
// Reset is synchronous and active low; it empties both registers and clears the record
// state, so the block is ready for a new buffer once reset is released.
// Depends on kvsp_pkg, kvsp_in_reg, kvsp_parser and key_value_stream_parser_macros.svh.
`include "key_value_stream_parser_macros.svh"

module key_value_stream_parser #(
    parameter int OFFSET_BITS      = kvsp_pkg::DEF_OFFSET_BITS,
    parameter int MAX_PREFIX_BYTES = kvsp_pkg::DEF_MAX_PREFIX_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kvsp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kvsp_pkg::t_out_item o_out_data
);
    import kvsp_pkg::*;

    logic      held_valid;
    t_in_item  held_item;
    logic      advance;
    t_out_item result;
    logic      r_out_valid;
    t_out_item r_out_data;

    assign advance = held_valid && (!r_out_valid || i_out_ready);

    kvsp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_data    (held_item)
    );

    kvsp_parser #(
        .OFFSET_BITS      (OFFSET_BITS),
        .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `KVSP_ASSERT_NXT(a_advance_fills_output, advance, r_out_valid, "Decoded byte was not captured.")
    `KVSP_ASSERT_NXT(a_held_byte_kept, held_valid && !advance, held_valid && $stable(held_item), "Held input byte was lost or changed before decode.")
    `KVSP_ASSERT_IMP(a_ignored_is_quiet, r_out_valid && (r_out_data.byte_role == ROLE_IGNORED), (r_out_data.status == ST_RUNNING) && (r_out_data.payload_size == '0) && !r_out_data.record_end, "Ignored byte carries record information.")
    `KVSP_ASSERT_IMP(a_record_end_status, r_out_valid && r_out_data.record_end, (r_out_data.status == ST_RUNNING) || (r_out_data.status == ST_DONE), "Record end reported together with an error.")

endmodule
